// ===== src/kvt_pkg.sv =====
// shared types and codes for the linear key-value table
package kvt_pkg;

  typedef enum logic [1:0] {
    KIND_SET = 2'd0,
    KIND_GET = 2'd1,
    KIND_DEL = 2'd2,
    KIND_CLR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    STATE_IDLE  = 2'd0,
    STATE_SCAN  = 2'd1,
    STATE_SHIFT = 2'd2,
    STATE_DONE  = 2'd3
  } state_e;

  typedef struct packed {
    logic    done;
    status_e status;
  } res_info_t;

endpackage

// ===== src/kvt_store.sv =====
// key and value store, one write port and one registered read port
module kvt_store #(
  parameter int DEPTH      = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [KEY_BITS-1:0]      wkey_i,
  input  logic [VALUE_BITS-1:0]    wval_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [KEY_BITS-1:0]      rkey_o,
  output logic [VALUE_BITS-1:0]    rval_o
);

  logic [KEY_BITS-1:0]   key_mem [DEPTH];
  logic [VALUE_BITS-1:0] val_mem [DEPTH];
  logic [KEY_BITS-1:0]   rkey_q;
  logic [VALUE_BITS-1:0] rval_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      val_mem[waddr_i] <= wval_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rkey_q <= key_mem[raddr_i];
    rval_q <= val_mem[raddr_i];
  end

  assign rkey_o = rkey_q;
  assign rval_o = rval_q;

endmodule

// ===== src/kvt_ctrl.sv =====
// sequencer with the shared key comparator, entry count and result state
module kvt_ctrl #(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   kind_i,
  input  logic [KEY_BITS-1:0]          key_i,
  input  logic [VALUE_BITS-1:0]        value_i,
  input  logic                         res_ready_i,
  output kvt_pkg::res_info_t           res_o,
  output logic [VALUE_BITS-1:0]        rd_value_o,
  output logic [$clog2(ENTRIES+1)-1:0] count_o,
  output logic                         mem_we_o,
  output logic [$clog2(ENTRIES)-1:0]   mem_waddr_o,
  output logic [KEY_BITS-1:0]          mem_wkey_o,
  output logic [VALUE_BITS-1:0]        mem_wval_o,
  output logic [$clog2(ENTRIES)-1:0]   mem_raddr_o,
  input  logic [KEY_BITS-1:0]          mem_rkey_i,
  input  logic [VALUE_BITS-1:0]        mem_rval_i
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  kvt_pkg::state_e       state_q, state_d;
  kvt_pkg::kind_e        kind_q, kind_d;
  kvt_pkg::status_e      status_q, status_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [VALUE_BITS-1:0] rdval_q, rdval_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         count_q, count_d;

  logic accept;
  logic empty;
  logic full;
  logic hit;
  logic last;

  assign accept = in_valid_i && (state_q == kvt_pkg::STATE_IDLE);
  assign empty  = (count_q == '0);
  assign full   = (count_q == CW'(ENTRIES));
  // the one comparator: stored key at idx_q against the key of this word
  assign hit    = !empty && (mem_rkey_i == key_q);
  assign last   = ((CW'(idx_q) + CW'(1)) == count_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kvt_pkg::STATE_IDLE: begin
        if (accept) begin
          if (kvt_pkg::kind_e'(kind_i) == kvt_pkg::KIND_CLR) begin
            state_d = kvt_pkg::STATE_DONE;
          end else begin
            state_d = kvt_pkg::STATE_SCAN;
          end
        end
      end
      kvt_pkg::STATE_SCAN: begin
        if (hit) begin
          if (kind_q == kvt_pkg::KIND_DEL && !last) begin
            state_d = kvt_pkg::STATE_SHIFT;
          end else begin
            state_d = kvt_pkg::STATE_DONE;
          end
        end else if (empty || last) begin
          state_d = kvt_pkg::STATE_DONE;
        end
      end
      kvt_pkg::STATE_SHIFT: begin
        if (last) begin
          state_d = kvt_pkg::STATE_DONE;
        end
      end
      kvt_pkg::STATE_DONE: begin
        if (res_ready_i) begin
          state_d = kvt_pkg::STATE_IDLE;
        end
      end
      default: state_d = kvt_pkg::STATE_IDLE;
    endcase
  end

  // datapath and memory port
  always_comb begin
    kind_d      = kind_q;
    key_d       = key_q;
    val_d       = val_q;
    idx_d       = idx_q;
    count_d     = count_q;
    status_d    = status_q;
    rdval_d     = rdval_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wkey_o  = key_q;
    mem_wval_o  = val_q;
    mem_raddr_o = idx_q + AW'(1);
    unique case (state_q)
      kvt_pkg::STATE_IDLE: begin
        mem_raddr_o = '0;
        if (accept) begin
          kind_d   = kvt_pkg::kind_e'(kind_i);
          key_d    = key_i;
          val_d    = value_i;
          idx_d    = '0;
          status_d = kvt_pkg::ST_OK;
          rdval_d  = '0;
          if (kvt_pkg::kind_e'(kind_i) == kvt_pkg::KIND_CLR) begin
            count_d = '0;
          end
        end
      end
      kvt_pkg::STATE_SCAN: begin
        if (hit) begin
          unique case (kind_q)
            kvt_pkg::KIND_SET: mem_we_o = 1'b1;
            kvt_pkg::KIND_GET: rdval_d = mem_rval_i;
            kvt_pkg::KIND_DEL: begin
              if (last) begin
                count_d = count_q - CW'(1);
              end else begin
                idx_d = idx_q + AW'(1);
              end
            end
            default: ;
          endcase
        end else if (empty || last) begin
          unique case (kind_q)
            kvt_pkg::KIND_SET: begin
              if (full) begin
                status_d = kvt_pkg::ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = count_q[AW-1:0];
                count_d     = count_q + CW'(1);
              end
            end
            default: status_d = kvt_pkg::ST_MISSING;
          endcase
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      kvt_pkg::STATE_SHIFT: begin
        // entry at idx_q moves down one place while idx_q + 1 is read
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q - AW'(1);
        mem_wkey_o  = mem_rkey_i;
        mem_wval_o  = mem_rval_i;
        if (last) begin
          count_d = count_q - CW'(1);
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kvt_pkg::STATE_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    key_q    <= key_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    rdval_q  <= rdval_d;
  end

  assign in_stall_o    = (state_q != kvt_pkg::STATE_IDLE);
  assign res_o.done    = (state_q == kvt_pkg::STATE_DONE);
  assign res_o.status  = status_q;
  assign rd_value_o    = rdval_q;
  assign count_o       = count_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("entry count above table size");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i == kvt_pkg::KIND_CLR) |=> (count_q == '0))
    else $error("clear did not empty the table");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == kvt_pkg::STATE_SCAN || state_q == kvt_pkg::STATE_SHIFT))
    else $error("store written outside an operation");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kvt_pkg::STATE_SHIFT) |-> (CW'(mem_waddr_o) < count_q))
    else $error("shift writes beyond the held entries");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.done && res_o.status == kvt_pkg::ST_FULL) |-> full)
    else $error("full reported on a table with room");
`endif

endmodule

// ===== src/linear_key_value_table.sv =====
// linear-search key-value table: top level with store, sequencer and result register
//
//   channel  direction  handshake                 word
//   in       input      in_valid_i / in_stall_o   kind_i, key_i, value_i
//   out      output     out_valid_o / out_stall_i status_o, read_value_o, entry_count_o
//
// one word at a time; a clear needs no scan, other words scan the slots from slot 0
//   to a hit or the last held entry, and a delete moves each later entry down one slot
// the single key comparator walks the store through its one registered read port
// reset clears the sequencer, the entry count and the output valid, not the store
// a stalled result holds in the output register while a new word is taken; the
//   sequencer waits at its end only if the register is still full
module linear_key_value_table #(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   kind_i,
  input  logic [KEY_BITS-1:0]          key_i,
  input  logic [VALUE_BITS-1:0]        value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic [VALUE_BITS-1:0]        read_value_o,
  output logic [$clog2(ENTRIES+1)-1:0] entry_count_o
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  // store port between sequencer and memory
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [KEY_BITS-1:0]   mem_wkey;
  logic [VALUE_BITS-1:0] mem_wval;
  logic [AW-1:0]         mem_raddr;
  logic [KEY_BITS-1:0]   mem_rkey;
  logic [VALUE_BITS-1:0] mem_rval;

  // finished result from the sequencer
  kvt_pkg::res_info_t    res;
  logic [VALUE_BITS-1:0] res_value;
  logic [CW-1:0]         res_count;
  logic                  res_ready;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [1:0]            status_q, status_d;
  logic [VALUE_BITS-1:0] read_value_q, read_value_d;
  logic [CW-1:0]         entry_count_q, entry_count_d;

  kvt_store #(
    .DEPTH      (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wkey_i  (mem_wkey),
    .wval_i  (mem_wval),
    .raddr_i (mem_raddr),
    .rkey_o  (mem_rkey),
    .rval_o  (mem_rval)
  );

  kvt_ctrl #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_value_o  (res_value),
    .count_o     (res_count),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wkey_o  (mem_wkey),
    .mem_wval_o  (mem_wval),
    .mem_raddr_o (mem_raddr),
    .mem_rkey_i  (mem_rkey),
    .mem_rval_i  (mem_rval)
  );

  // room in the output register: empty, or its word leaves this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d   = out_valid_q;
    status_d      = status_q;
    read_value_d  = read_value_q;
    entry_count_d = entry_count_q;
    if (res.done && res_ready) begin
      out_valid_d   = 1'b1;
      status_d      = res.status;
      read_value_d  = res_value;
      entry_count_d = res_count;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q      <= status_d;
    read_value_q  <= read_value_d;
    entry_count_q <= entry_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_value_o  = read_value_q;
  assign entry_count_o = entry_count_q;

endmodule
